>>> rtl/iir_biquad_transposed_df2_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the biquad filter
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IIR_BIQUAD_TRANSPOSED_DF2_MACROS_SVH
`define IIR_BIQUAD_TRANSPOSED_DF2_MACROS_SVH

// check consequent in the same cycle
`define IIRBQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check consequent in the next cycle
`define IIRBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iirbq_pkg.sv
// ----------------------------------------------------------------------------
// iirbq_pkg
// Types, widths and saturation helpers for the biquad filter.
// ----------------------------------------------------------------------------
package iirbq_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 18;
  localparam int COEF_FRAC_BITS = 14;
  localparam int STATE_BITS     = 40;
  localparam int NUM_CELLS      = 2;
  localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS       = ((PROD_BITS > STATE_BITS) ? PROD_BITS : STATE_BITS) + 2;

  localparam int IN_IDX_LSB     = SAMPLE_BITS;
  localparam int IN_VAL_LSB     = SAMPLE_BITS + 1;
  localparam int IN_DATA_BITS   = ((SAMPLE_BITS + 1 + STATE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic signed [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [STATE_BITS-1:0]  STATE_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0]  STATE_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0]    ROUND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_LOAD   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y,
    ST_B1,
    ST_B2,
    ST_A1,
    ST_A2
  } state_t;

  typedef enum logic [2:0] {
    MS_B0_IN,
    MS_B1_X,
    MS_B2_X,
    MS_A1_Y,
    MS_A2_Y
  } mul_sel_t;

  typedef struct packed {
    logic clear;
    logic wr;
    logic load;
    logic add;
    logic sub;
    logic commit;
  } cell_ctl_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     mul_en;
    logic     x_load;
    logic     y_load;
    logic     out_push;
  } seq_t;

  typedef struct packed {
    logic                   sat;
    logic [SAMPLE_BITS-1:0] val;
  } sat_sample_t;

  function automatic sat_sample_t sat_sample(input logic signed [ACC_BITS-1:0] v);
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    sat_sample_t                res;
    hi = ACC_BITS'(SAMPLE_MAX);
    lo = ACC_BITS'(SAMPLE_MIN);
    if (v > hi) begin
      res = '{sat: 1'b1, val: SAMPLE_MAX};
    end else if (v < lo) begin
      res = '{sat: 1'b1, val: SAMPLE_MIN};
    end else begin
      res = '{sat: 1'b0, val: v[SAMPLE_BITS-1:0]};
    end
    return res;
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [ACC_BITS-1:0]   hi;
    logic signed [ACC_BITS-1:0]   lo;
    logic signed [STATE_BITS-1:0] res;
    hi = ACC_BITS'(STATE_MAX);
    lo = ACC_BITS'(STATE_MIN);
    if (v > hi) begin
      res = STATE_MAX;
    end else if (v < lo) begin
      res = STATE_MIN;
    end else begin
      res = v[STATE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/iir_biquad_transposed_df2.sv
// ----------------------------------------------------------------------------
// iir_biquad_transposed_df2
// Second-order IIR filter, transposed direct form II, one shared multiplier.
// ----------------------------------------------------------------------------
// A sample steps through ST_Y, ST_B1, ST_B2, ST_A1 and ST_A2, which loads the
//   result into the output register behind out_tvalid. No new sample is taken
//   until the five coefficient products on the single 18x16 multiplier and
//   the commit of both delays are done; a result still waiting in the output
//   register holds the commit. Clear and load act on acceptance, with no result.
// Reset: b0 = 1.0, other coefficients 0, delay line zero, output register empty.
// ----------------------------------------------------------------------------
`include "iir_biquad_transposed_df2_macros.svh"

module iir_biquad_transposed_df2
  import iirbq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // config write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [COEF_BITS-1:0]     cfg_data,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // [15:0] sample_in, [16] delay_index, [56:17] delay_value, [63:57] zero
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // [1:0] opcode
  input  logic [1:0]               in_tuser,
  // output stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [15:0] sample_out
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // [0] saturated
  output logic                     out_tuser
);

  logic signed [COEF_BITS-1:0]   b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [SAMPLE_BITS-1:0] x_r, y_r;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic signed [STATE_BITS-1:0]  load_value;
  logic signed [PROD_BITS-1:0]   prod_r, prod_nxt;
  logic signed [COEF_BITS-1:0]   mul_coef;
  logic signed [SAMPLE_BITS-1:0] mul_data;
  logic signed [ACC_BITS-1:0]    y_wide;
  logic signed [ACC_BITS-1:0]    y_shift;
  sat_sample_t                   y_sat;
  logic                          y_flag_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]        out_data_r;
  logic                          out_sat_r;
  logic                          out_busy;
  logic signed [STATE_BITS-1:0]  delay [NUM_CELLS];
  cell_ctl_t [NUM_CELLS-1:0]     cell_ctl;
  seq_t                          seq;

  assign x_in       = signed'(in_tdata[SAMPLE_BITS-1:0]);
  assign load_value = signed'(in_tdata[IN_VAL_LSB +: STATE_BITS]);
  assign cfg_ready  = 1'b1;
  assign out_busy   = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_t'(cfg_index))
        REG_B0:  b0_r <= signed'(cfg_data);
        REG_B1:  b1_r <= signed'(cfg_data);
        REG_B2:  b2_r <= signed'(cfg_data);
        REG_A1:  a1_r <= signed'(cfg_data);
        REG_A2:  a2_r <= signed'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  iirbq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .opcode      (op_t'(in_tuser)),
    .delay_index (in_tdata[IN_IDX_LSB]),
    .out_busy    (out_busy),
    .in_tready   (in_tready),
    .cell_ctl    (cell_ctl),
    .seq         (seq)
  );

  always_comb begin
    case (seq.mul_sel)
      MS_B0_IN: begin
        mul_coef = b0_r;
        mul_data = x_in;
      end
      MS_B1_X: begin
        mul_coef = b1_r;
        mul_data = x_r;
      end
      MS_B2_X: begin
        mul_coef = b2_r;
        mul_data = x_r;
      end
      MS_A1_Y: begin
        mul_coef = a1_r;
        mul_data = y_r;
      end
      MS_A2_Y: begin
        mul_coef = a2_r;
        mul_data = y_r;
      end
      default: begin
        mul_coef = b0_r;
        mul_data = x_in;
      end
    endcase
  end

  assign prod_nxt = mul_coef * mul_data;

  always_ff @(posedge clk) begin
    if (seq.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (seq.x_load) begin
      x_r <= x_in;
    end
  end

  // round half up, then clip to sample range
  assign y_wide  = ACC_BITS'(delay[0]) + ACC_BITS'(prod_r) + ROUND_HALF;
  assign y_shift = y_wide >>> COEF_FRAC_BITS;
  assign y_sat   = sat_sample(y_shift);

  always_ff @(posedge clk) begin
    if (seq.y_load) begin
      y_r      <= signed'(y_sat.val);
      y_flag_r <= y_sat.sat;
    end
  end

  generate
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      logic signed [STATE_BITS-1:0] chain_in;
      if (k == NUM_CELLS - 1) begin : g_last
        assign chain_in = '0;
      end else begin : g_mid
        assign chain_in = delay[k+1];
      end
      iirbq_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl[k]),
        .chain_in (chain_in),
        .prod     (prod_r),
        .wr_value (load_value),
        .delay    (delay[k])
      );
    end
  endgenerate

  assign out_valid_nxt = seq.out_push || out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.out_push) begin
      out_data_r <= y_r;
      out_sat_r  <= y_flag_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_BITS'(out_data_r);
  assign out_tuser  = out_sat_r;

  `IIRBQ_ASSERT_SAME(a_sat_at_rail, out_valid_r && out_sat_r,
                     out_data_r == SAMPLE_MAX || out_data_r == SAMPLE_MIN,
                     "saturated flag set on a value off the rails")
  `IIRBQ_ASSERT_NEXT(a_clear_zeroes, in_tvalid && in_tready && in_tuser == OP_CLEAR,
                     delay[0] == '0 && delay[1] == '0,
                     "clear left a nonzero delay")
  `IIRBQ_ASSERT_SAME(a_no_overwrite, seq.out_push, !out_busy,
                     "result pushed over an untaken result")

endmodule

>>> rtl/iirbq_cell.sv
// ----------------------------------------------------------------------------
// iirbq_cell
// One delay element of the transposed structure with its accumulator.
// ----------------------------------------------------------------------------
module iirbq_cell
  import iirbq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  cell_ctl_t                    ctl,
  input  logic signed [STATE_BITS-1:0] chain_in,
  input  logic signed [PROD_BITS-1:0]  prod,
  input  logic signed [STATE_BITS-1:0] wr_value,
  output logic signed [STATE_BITS-1:0] delay
);

  logic signed [STATE_BITS-1:0] delay_r, delay_nxt;
  logic signed [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic signed [ACC_BITS-1:0]   operand;
  logic signed [ACC_BITS-1:0]   acc_sum;

  always_comb begin
    if (ctl.add) begin
      operand = ACC_BITS'(prod);
    end else if (ctl.sub) begin
      operand = -ACC_BITS'(prod);
    end else begin
      operand = '0;
    end
  end

  assign acc_sum = acc_r + operand;

  always_comb begin
    if (ctl.load) begin
      acc_nxt = ACC_BITS'(chain_in);
    end else if (ctl.add || ctl.sub) begin
      acc_nxt = acc_sum;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_comb begin
    if (ctl.clear) begin
      delay_nxt = '0;
    end else if (ctl.wr) begin
      delay_nxt = wr_value;
    end else if (ctl.commit) begin
      delay_nxt = sat_state(acc_sum);
    end else begin
      delay_nxt = delay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
    end else begin
      delay_r <= delay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign delay = delay_r;

endmodule

>>> rtl/iirbq_ctrl.sv
// ----------------------------------------------------------------------------
// iirbq_ctrl
// Sequencer: schedules the shared multiplier and the delay cells.
// ----------------------------------------------------------------------------
`include "iir_biquad_transposed_df2_macros.svh"

module iirbq_ctrl
  import iirbq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  op_t                         opcode,
  input  logic                        delay_index,
  input  logic                        out_busy,
  output logic                        in_tready,
  output cell_ctl_t [NUM_CELLS-1:0]   cell_ctl,
  output seq_t                        seq
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && opcode == OP_SAMPLE) begin
          state_nxt = ST_Y;
        end
      end
      ST_Y:  state_nxt = ST_B1;
      ST_B1: state_nxt = ST_B2;
      ST_B2: state_nxt = ST_A1;
      ST_A1: state_nxt = ST_A2;
      ST_A2: begin
        if (!out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cell_ctl    = '0;
    seq         = '0;
    seq.mul_sel = MS_B0_IN;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          case (opcode)
            OP_SAMPLE: begin
              seq.mul_en = 1'b1;
              seq.x_load = 1'b1;
            end
            OP_CLEAR: begin
              cell_ctl[0].clear = 1'b1;
              cell_ctl[1].clear = 1'b1;
            end
            OP_LOAD: begin
              cell_ctl[delay_index].wr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_Y: begin
        seq.y_load       = 1'b1;
        seq.mul_en       = 1'b1;
        seq.mul_sel      = MS_B1_X;
        cell_ctl[0].load = 1'b1;
        cell_ctl[1].load = 1'b1;
      end
      ST_B1: begin
        seq.mul_en      = 1'b1;
        seq.mul_sel     = MS_B2_X;
        cell_ctl[0].add = 1'b1;
      end
      ST_B2: begin
        seq.mul_en      = 1'b1;
        seq.mul_sel     = MS_A1_Y;
        cell_ctl[1].add = 1'b1;
      end
      ST_A1: begin
        seq.mul_en      = 1'b1;
        seq.mul_sel     = MS_A2_Y;
        cell_ctl[0].sub = 1'b1;
      end
      ST_A2: begin
        if (!out_busy) begin
          seq.out_push       = 1'b1;
          cell_ctl[0].commit = 1'b1;
          cell_ctl[1].sub    = 1'b1;
          cell_ctl[1].commit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `IIRBQ_ASSERT_SAME(a_load_one_cell, 1'b1, $onehot0({cell_ctl[1].wr, cell_ctl[0].wr}),
                     "load wrote both delay cells")
  `IIRBQ_ASSERT_NEXT(a_sample_starts, accept && opcode == OP_SAMPLE, state_r == ST_Y,
                     "accepted sample did not start the sequence")
  `IIRBQ_ASSERT_NEXT(a_stall_holds, state_r == ST_A2 && out_busy, state_r == ST_A2,
                     "final step left while output register full")

endmodule

>>> test/iir_biquad_transposed_df2_tb.sv
// ----------------------------------------------------------------------------
// iir_biquad_transposed_df2_tb
// Self-checking bench for the transposed direct form II biquad. A directed
// table covers the sample extremes, saturation from loaded delays, rounding
// at the half LSB, clear, load and the unused opcode. Random traffic then runs
// under eight coefficient settings, from a realistic lowpass to all-max and
// all-min. Both stream sides stall at random. Every sample result is checked
// against a bit-accurate predictor, or for typed table rows the expected value.
// ----------------------------------------------------------------------------
module iir_biquad_transposed_df2_tb;
  import iirbq_pkg::*;

  localparam logic [1:0]           OP_UNUSED       = 2'd3;
  localparam logic [COEF_BITS-1:0] COEF_MAX        = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0] COEF_MIN        = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam longint               SAMP_HI         = (longint'(1) << (SAMPLE_BITS-1)) - 1;
  localparam longint               STATE_HI        = (longint'(1) << (STATE_BITS-1)) - 1;
  localparam int                   N_DIRECTED      = 27;
  localparam int                   N_PHASES        = 8;
  localparam int                   ITEMS_PER_PHASE = 240;
  localparam int                   SETTLE_CYCLES   = 12;
  localparam int                   LONG_HOLD       = 300;
  localparam int                   IDLE_LIMIT      = 4000;
  localparam int                   MAX_REPORTS     = 10;

  typedef struct packed {
    logic [1:0]             op;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   idx;
    logic [STATE_BITS-1:0]  value;
    logic                   typed;
    logic [SAMPLE_BITS-1:0] exp_y;
    logic                   exp_sat;
  } dir_row_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] y;
    logic                   sat;
  } filt_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [COEF_BITS-1:0]     cfg_data;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic [1:0]               in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tuser;

  logic signed [COEF_BITS-1:0]  coef_q [5];
  logic signed [STATE_BITS-1:0] delay_q [2];
  filt_result_t                 pending_samples [$];

  int fail_count;
  int n_samples;
  int n_clears;
  int n_loads;
  int n_unused;
  int n_sat;
  int n_checked;
  int cfg_writes;
  int burst_left;
  bit park_req;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{OP_SAMPLE, 16'sd0,      1'b0, 40'sd0,      1'b1, 16'sd0,      1'b0},
    '{OP_SAMPLE, SAMPLE_MAX,  1'b0, 40'sd0,      1'b1, SAMPLE_MAX,  1'b0},
    '{OP_SAMPLE, SAMPLE_MIN,  1'b0, 40'sd0,      1'b1, SAMPLE_MIN,  1'b0},
    '{OP_SAMPLE, 16'sd1,      1'b0, 40'sd0,      1'b1, 16'sd1,      1'b0},
    '{OP_SAMPLE, -16'sd1,     1'b0, 40'sd0,      1'b1, -16'sd1,     1'b0},
    '{OP_SAMPLE, 16'h5555,    1'b0, 40'sd0,      1'b1, 16'h5555,    1'b0},
    '{OP_SAMPLE, 16'hAAAA,    1'b0, 40'sd0,      1'b1, 16'hAAAA,    1'b0},
    '{OP_LOAD,   16'hFFFF,    1'b0, STATE_MAX,   1'b0, 16'sd0,      1'b0},
    '{OP_SAMPLE, 16'sd0,      1'b0, 40'sd0,      1'b1, SAMPLE_MAX,  1'b1},
    '{OP_LOAD,   16'sd0,      1'b0, STATE_MIN,   1'b0, 16'sd0,      1'b0},
    '{OP_SAMPLE, 16'sd0,      1'b0, 40'sd0,      1'b1, SAMPLE_MIN,  1'b1},
    '{OP_LOAD,   16'sd0,      1'b1, 40'sd81920,  1'b0, 16'sd0,      1'b0},
    '{OP_SAMPLE, 16'sd0,      1'b0, 40'sd0,      1'b0, 16'sd0,      1'b0},
    '{OP_SAMPLE, 16'sd0,      1'b0, 40'sd0,      1'b0, 16'sd0,      1'b0},
    '{OP_LOAD,   16'sd0,      1'b1, STATE_MAX,   1'b0, 16'sd0,      1'b0},
    '{OP_LOAD,   16'sd0,      1'b0, 40'sd1234567, 1'b0, 16'sd0,     1'b0},
    '{OP_CLEAR,  16'h7FFF,    1'b1, STATE_MAX,   1'b0, 16'sd0,      1'b0},
    '{OP_SAMPLE, 16'sd100,    1'b0, 40'sd0,      1'b1, 16'sd100,    1'b0},
    '{OP_UNUSED, 16'h7FFF,    1'b1, STATE_MAX,   1'b0, 16'sd0,      1'b0},
    '{OP_SAMPLE, -16'sd100,   1'b0, 40'sd0,      1'b1, -16'sd100,   1'b0},
    '{OP_LOAD,   16'sd0,      1'b0, 40'sd8192,   1'b0, 16'sd0,      1'b0},
    '{OP_SAMPLE, 16'sd0,      1'b0, 40'sd0,      1'b0, 16'sd0,      1'b0},
    '{OP_LOAD,   16'sd0,      1'b0, -40'sd8193,  1'b0, 16'sd0,      1'b0},
    '{OP_SAMPLE, 16'sd0,      1'b0, 40'sd0,      1'b0, 16'sd0,      1'b0},
    '{OP_LOAD,   16'sd0,      1'b0, -40'sd8192,  1'b0, 16'sd0,      1'b0},
    '{OP_SAMPLE, 16'sd0,      1'b0, 40'sd0,      1'b0, 16'sd0,      1'b0},
    '{OP_CLEAR,  16'sd0,      1'b0, 40'sd0,      1'b0, 16'sd0,      1'b0}
  };

  iir_biquad_transposed_df2 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_to(input longint v, input longint hi);
    if (v > hi) begin
      return hi;
    end else if (v < -hi - 1) begin
      return -hi - 1;
    end
    return v;
  endfunction

  function automatic void predict_biquad(
    input  logic [1:0]                    op,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic                          idx,
    input  logic signed [STATE_BITS-1:0]  value,
    output bit                            has_out,
    output filt_result_t                  res
  );
    longint x;
    longint yw;
    longint r;
    longint y;
    longint z0;
    longint z1;
    has_out = 1'b0;
    res.y   = '0;
    res.sat = 1'b0;
    if (op == OP_CLEAR) begin
      delay_q[0] = '0;
      delay_q[1] = '0;
    end else if (op == OP_LOAD) begin
      delay_q[idx] = value;
    end else if (op == OP_SAMPLE) begin
      x  = longint'(x_in);
      yw = longint'(delay_q[0]) + longint'(coef_q[REG_B0]) * x;
      r  = (yw + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      y  = clamp_to(r, SAMP_HI);
      z0 = longint'(delay_q[1]) + longint'(coef_q[REG_B1]) * x
           - longint'(coef_q[REG_A1]) * y;
      z1 = longint'(coef_q[REG_B2]) * x - longint'(coef_q[REG_A2]) * y;
      delay_q[0] = STATE_BITS'(clamp_to(z0, STATE_HI));
      delay_q[1] = STATE_BITS'(clamp_to(z1, STATE_HI));
      has_out = 1'b1;
      res.y   = SAMPLE_BITS'(y);
      res.sat = (y != r);
    end
  endfunction

  function automatic int pick_gap();
    int unsigned sel;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end else if (sel < 50) begin
      return 0;
    end else if (sel < 85) begin
      return $urandom_range(1, 3);
    end else if (sel < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [4:0][COEF_BITS-1:0] coef_setting(input int p);
    logic [4:0][COEF_BITS-1:0] c;
    for (int i = REG_B0; i <= REG_A2; i++) begin
      c[i] = COEF_BITS'($urandom);
    end
    case (p)
      0: begin
        c[REG_B0] = 18'sd1106;
        c[REG_B1] = 18'sd2212;
        c[REG_B2] = 18'sd1106;
        c[REG_A1] = -18'sd18727;
        c[REG_A2] = 18'sd6763;
      end
      1: c = {5{COEF_MAX}};
      2: c = {5{COEF_MIN}};
      4: begin
        c = '0;
        c[REG_B0] = B0_RESET;
      end
      6: begin
        for (int i = REG_B0; i <= REG_A2; i++) begin
          case ($urandom_range(0, 2))
            0:       c[i] = COEF_MAX;
            1:       c[i] = COEF_MIN;
            default: c[i] = '0;
          endcase
        end
      end
      7: begin
        c[REG_B0] = 18'sd4096;
        c[REG_B1] = 18'sd0;
        c[REG_B2] = -18'sd4096;
        c[REG_A1] = -18'sd31000;
        c[REG_A2] = 18'sd16000;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic write_coefs(input logic [4:0][COEF_BITS-1:0] vals);
    for (int i = REG_B0; i <= REG_A2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      coef_q[i] = vals[i];
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(
    input logic [1:0]             op,
    input logic [SAMPLE_BITS-1:0] sample,
    input logic                   idx,
    input logic [STATE_BITS-1:0]  value,
    input logic                   typed,
    input logic [SAMPLE_BITS-1:0] exp_y,
    input logic                   exp_sat
  );
    int           gap;
    bit           has_out;
    filt_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_BITS'({value, idx, sample});
    do @(posedge clk); while (!in_tready);
    predict_biquad(op, sample, idx, value, has_out, res);
    case (op)
      OP_SAMPLE: n_samples++;
      OP_CLEAR:  n_clears++;
      OP_LOAD:   n_loads++;
      default:   n_unused++;
    endcase
    if (has_out) begin
      if (typed) begin
        res.y   = exp_y;
        res.sat = exp_sat;
      end
      pending_samples.push_back(res);
    end
  endtask

  task automatic send_random_item(output bit counts);
    int unsigned           sel;
    logic [1:0]            op;
    logic [SAMPLE_BITS-1:0] s;
    logic [STATE_BITS-1:0] v;
    logic [31:0]           r;
    sel = $urandom_range(0, 99);
    if (sel < 84) begin
      op = OP_SAMPLE;
    end else if (sel < 90) begin
      op = OP_LOAD;
    end else if (sel < 94) begin
      op = OP_CLEAR;
    end else begin
      op = OP_UNUSED;
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      s = SAMPLE_MAX;
    end else if (sel == 1) begin
      s = SAMPLE_MIN;
    end else if (sel < 4) begin
      s = SAMPLE_BITS'($urandom_range(0, 1023)) - SAMPLE_BITS'(512);
    end else begin
      s = SAMPLE_BITS'($urandom);
    end
    r   = $urandom;
    sel = $urandom_range(0, 5);
    if (sel == 0) begin
      v = STATE_MAX;
    end else if (sel == 1) begin
      v = STATE_MIN;
    end else if (sel < 4) begin
      v = {{(STATE_BITS-20){r[19]}}, r[19:0]};
    end else begin
      v = {8'($urandom), r};
    end
    send_item(op, s, 1'($urandom_range(0, 1)), v, 1'b0, '0, 1'b0);
    counts = (op != OP_UNUSED);
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random backpressure, long hold on request
  initial begin
    int           run_left;
    int           stall_left;
    int unsigned  sel;
    filt_result_t want;
    out_tready = 1'b0;
    run_left   = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        n_checked++;
        if (pending_samples.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("ERROR: unexpected output transaction y=%0d sat=%0b",
                     $signed(out_tdata[SAMPLE_BITS-1:0]), out_tuser);
          end
        end else begin
          want = pending_samples.pop_front();
          if (out_tdata[SAMPLE_BITS-1:0] !== want.y || out_tuser !== want.sat) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("ERROR: output %0d expected y=%0d sat=%0b, got y=%0d sat=%0b",
                       n_checked, $signed(want.y), want.sat,
                       $signed(out_tdata[SAMPLE_BITS-1:0]), out_tuser);
            end
          end else if (want.sat) begin
            n_sat++;
          end
        end
      end
      if (park_req) begin
        park_req   = 1'b0;
        run_left   = 0;
        stall_left = LONG_HOLD;
      end
      if (run_left == 0 && stall_left == 0) begin
        run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(0, 6);
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
          stall_left = $urandom_range(1, 3);
        end else if (sel < 19) begin
          stall_left = $urandom_range(4, 10);
        end else begin
          stall_left = $urandom_range(15, 40);
        end
      end
      if (run_left > 0) begin
        out_tready <= 1'b1;
        run_left--;
      end else begin
        out_tready <= 1'b0;
        stall_left--;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int counted;
    bit counts;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    park_req   = 1'b0;
    burst_left = 0;
    fail_count = 0;
    n_samples  = 0;
    n_clears   = 0;
    n_loads    = 0;
    n_unused   = 0;
    n_sat      = 0;
    n_checked  = 0;
    cfg_writes = 0;
    coef_q[REG_B0] = B0_RESET;
    for (int i = REG_B1; i <= REG_A2; i++) begin
      coef_q[i] = '0;
    end
    delay_q[0] = '0;
    delay_q[1] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_DIRECTED; k++) begin
      send_item(dir_rows[k].op, dir_rows[k].sample, dir_rows[k].idx, dir_rows[k].value,
                dir_rows[k].typed, dir_rows[k].exp_y, dir_rows[k].exp_sat);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_and_settle();
      write_coefs(coef_setting(p));
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if (p == 3 && counted == 60) begin
          park_req = 1'b1;
        end
        send_random_item(counts);
        if (counts) begin
          counted++;
        end
      end
    end

    drain_and_settle();
    $display("Run covered %0d samples (%0d saturated), %0d loads, %0d clears, %0d unused",
             n_samples, n_sat, n_loads, n_clears, n_unused);
    $display("opcodes, %0d coefficient writes over %0d settings; %0d results checked",
             cfg_writes, N_PHASES, n_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
